// ===== sv/clnw_pkg.sv =====
// ----------------------------------------------------------------------------
// clnw_pkg - shared types and constants for the character LCD nibble writer
// Request codes, queue entry layout, LCD command bytes and bus timing values.
// ----------------------------------------------------------------------------
package clnw_pkg;

  // Request codes on req_type_i
  typedef enum logic [1:0] {
    REQ_PUT   = 2'd0,
    REQ_SET   = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_INIT  = 2'd3
  } req_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_LINE_LENGTH = 2'd0,
    CFG_LINE_COUNT  = 2'd1,
    CFG_STROBE_US   = 2'd2
  } cfg_e;

  // Kind of write sequence queued for the back end
  typedef enum logic [1:0] {
    KIND_CHAR  = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_INIT  = 2'd2
  } kind_e;

  // One queued sequence: DDRAM address command byte and data byte
  typedef struct packed {
    kind_e      kind;
    logic [7:0] addr_cmd;
    logic [7:0] data;
  } entry_t;

  localparam logic [7:0] NEWLINE_CODE = 8'h0a;

  localparam logic [5:0] LINE_LENGTH_RST = 6'd16;
  localparam logic [1:0] LINE_COUNT_RST  = 2'd2;

  // HD44780 command bytes
  localparam logic [7:0] CMD_FUNC_SET  = 8'h28;
  localparam logic [7:0] CMD_DISP_ON   = 8'h0c;
  localparam logic [7:0] CMD_ENTRY     = 8'h06;
  localparam logic [7:0] CMD_CLEAR     = 8'h01;
  localparam logic [3:0] NIB_WAKE      = 4'h3;
  localparam logic [3:0] NIB_4BIT      = 4'h2;

  // Delays in microseconds
  localparam logic [14:0] PWR_ON_US    = 15'd20000;
  localparam logic [10:0] WAKE_US      = 11'd1000;
  localparam logic [10:0] CLEAR_US     = 11'd1800;

  // Longest sequence (initialise) and step counter width
  localparam int INIT_WRITES = 14;
  localparam int STEP_W      = 4;

endpackage

// ===== sv/clnw_front.sv =====
// ----------------------------------------------------------------------------
// clnw_front - request decoder and cursor tracker
// Accepts requests, updates the cursor and queues write sequences.
// ----------------------------------------------------------------------------
module clnw_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration writes
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [7:0]           cfg_data_i,
  // request word
  input  logic                 req_valid_i,
  input  logic [1:0]           req_type_i,
  input  logic [7:0]           char_code_i,
  input  logic [5:0]           cursor_col_i,
  input  logic                 cursor_row_i,
  // queue side
  input  logic                 queue_full_i,
  output logic                 push_o,
  output clnw_pkg::entry_t     entry_o
);

  logic [5:0] line_length_q;
  logic [1:0] line_count_q;
  logic [5:0] col_q, col_d;
  logic       row_q, row_d;

  logic       accept;
  logic [1:0] lines_eff;
  logic [1:0] row_inc;
  logic       row_next;
  logic [6:0] col_inc;
  logic       col_wrap;

  assign accept = req_valid_i && !queue_full_i;

  // Next row with wrap; a line count of zero acts as one
  always_comb begin
    lines_eff = (line_count_q == 2'd0) ? 2'd1 : line_count_q;
    row_inc   = {1'b0, row_q} + 2'd1;
    row_next  = (row_inc >= lines_eff) ? 1'b0 : row_inc[0];
    col_inc   = {1'b0, col_q} + 7'd1;
    col_wrap  = col_inc >= {1'b0, line_length_q};
  end

  // Decode request
  always_comb begin
    push_o           = 1'b0;
    entry_o.kind     = clnw_pkg::KIND_CHAR;
    entry_o.addr_cmd = {1'b1, row_q, col_q};
    entry_o.data     = char_code_i;
    col_d            = col_q;
    row_d            = row_q;
    if (accept) begin
      case (clnw_pkg::req_e'(req_type_i))
        clnw_pkg::REQ_PUT: begin
          if (char_code_i == clnw_pkg::NEWLINE_CODE) begin
            col_d = 6'd0;
            row_d = row_next;
          end else begin
            push_o = 1'b1;
            if (col_wrap) begin
              col_d = 6'd0;
              row_d = row_next;
            end else begin
              col_d = col_inc[5:0];
            end
          end
        end
        clnw_pkg::REQ_SET: begin
          col_d = cursor_col_i;
          row_d = cursor_row_i;
        end
        clnw_pkg::REQ_CLEAR: begin
          push_o       = 1'b1;
          entry_o.kind = clnw_pkg::KIND_CLEAR;
          col_d        = 6'd0;
          row_d        = 1'b0;
        end
        clnw_pkg::REQ_INIT: begin
          push_o       = 1'b1;
          entry_o.kind = clnw_pkg::KIND_INIT;
          col_d        = 6'd0;
          row_d        = 1'b0;
        end
        default: begin
          push_o = 1'b0;
        end
      endcase
    end
  end

  // Cursor and configuration registers
  // strobe timing is applied by the pin driver, so index 2 is not kept here
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q         <= 6'd0;
      row_q         <= 1'b0;
      line_length_q <= clnw_pkg::LINE_LENGTH_RST;
      line_count_q  <= clnw_pkg::LINE_COUNT_RST;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (cfg_we_i) begin
        case (clnw_pkg::cfg_e'(cfg_index_i))
          clnw_pkg::CFG_LINE_LENGTH: line_length_q <= cfg_data_i[5:0];
          clnw_pkg::CFG_LINE_COUNT:  line_count_q  <= cfg_data_i[1:0];
          default: ;
        endcase
      end
    end
  end

  // Never push into a full queue
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !queue_full_i)
    else $error("push into full queue");

endmodule

// ===== sv/clnw_queue.sv =====
// ----------------------------------------------------------------------------
// clnw_queue - small FIFO between decoder and sequencer
// Holds queued write sequences so both sides stall independently.
// ----------------------------------------------------------------------------
module clnw_queue #(
  parameter int DEPTH = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  clnw_pkg::entry_t  push_entry_i,
  input  logic              pop_i,
  output logic              full_o,
  output logic              head_valid_o,
  output clnw_pkg::entry_t  head_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  clnw_pkg::entry_t mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  assign full_o       = count_q == CNT_W'(DEPTH);
  assign head_valid_o = count_q != '0;
  assign head_o       = mem_q[rd_ptr_q];

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    ptr_next = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ptr_next(wr_ptr_q);
      if (pop_i)  rd_ptr_q <= ptr_next(rd_ptr_q);
      if (push_i && !pop_i)      count_q <= count_q + CNT_W'(1);
      else if (pop_i && !push_i) count_q <= count_q - CNT_W'(1);
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_entry_i;
  end

endmodule

// ===== sv/clnw_back.sv =====
// ----------------------------------------------------------------------------
// clnw_back - nibble write sequencer
// Steps through the queued sequence, one nibble word per cycle while not stalled.
// ----------------------------------------------------------------------------
module clnw_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  clnw_pkg::entry_t  head_i,
  output logic              pop_o,
  output logic              wr_valid_o,
  input  logic              wr_stall_i,
  output logic [3:0]        nibble_o,
  output logic              reg_select_o,
  output logic [14:0]       pre_delay_us_o,
  output logic [10:0]       post_delay_us_o,
  output logic              last_o
);

  typedef struct packed {
    logic [3:0]  nibble;
    logic        rs;
    logic [14:0] pre;
    logic [10:0] post;
    logic        last;
  } write_t;

  logic [clnw_pkg::STEP_W-1:0] step_q;
  logic   wr_valid_q;
  write_t out_q;
  write_t cur;
  logic   advance, load;

  // Write for a given step of a sequence
  function automatic write_t write_at(input clnw_pkg::entry_t e,
                                      input logic [clnw_pkg::STEP_W-1:0] s);
    write_t w;
    logic [7:0] byte_v;
    w.nibble = 4'h0;
    w.rs     = 1'b0;
    w.pre    = 15'd0;
    w.post   = 11'd0;
    w.last   = 1'b0;
    byte_v   = 8'h00;
    case (e.kind)
      clnw_pkg::KIND_CHAR: begin
        byte_v   = s[1] ? e.data : e.addr_cmd;
        w.nibble = s[0] ? byte_v[3:0] : byte_v[7:4];
        w.rs     = s[1];
        w.last   = s[1:0] == 2'd3;
      end
      clnw_pkg::KIND_CLEAR: begin
        w.nibble = s[0] ? clnw_pkg::CMD_CLEAR[3:0] : clnw_pkg::CMD_CLEAR[7:4];
        w.post   = s[0] ? clnw_pkg::CLEAR_US : 11'd0;
        w.last   = s[0];
      end
      clnw_pkg::KIND_INIT: begin
        if (s < 4'd3) begin
          // wake-up nibbles, power-on wait before the first
          w.nibble = clnw_pkg::NIB_WAKE;
          w.pre    = (s == 4'd0) ? clnw_pkg::PWR_ON_US : 15'd0;
          w.post   = clnw_pkg::WAKE_US;
        end else if (s == 4'd3) begin
          w.nibble = clnw_pkg::NIB_4BIT;
        end else begin
          case (s[3:1])
            3'd2:    byte_v = clnw_pkg::CMD_FUNC_SET;
            3'd3:    byte_v = clnw_pkg::CMD_DISP_ON;
            3'd4:    byte_v = clnw_pkg::CMD_ENTRY;
            default: byte_v = clnw_pkg::CMD_CLEAR;
          endcase
          w.nibble = s[0] ? byte_v[3:0] : byte_v[7:4];
          w.last   = s == 4'(clnw_pkg::INIT_WRITES - 1);
          w.post   = w.last ? clnw_pkg::CLEAR_US : 11'd0;
        end
      end
      default: begin
        w.last = 1'b1;
      end
    endcase
    write_at = w;
  endfunction

  assign advance = !wr_valid_q || !wr_stall_i;
  assign load    = advance && head_valid_i;
  assign cur     = write_at(head_i, step_q);
  assign pop_o   = load && cur.last;

  // Step counter and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q     <= '0;
      wr_valid_q <= 1'b0;
    end else begin
      if (advance) wr_valid_q <= head_valid_i;
      if (load)    step_q <= cur.last ? '0 : step_q + 4'd1;
    end
  end

  // Output word register
  always_ff @(posedge clk_i) begin
    if (load) out_q <= cur;
  end

  assign wr_valid_o      = wr_valid_q;
  assign nibble_o        = out_q.nibble;
  assign reg_select_o    = out_q.rs;
  assign pre_delay_us_o  = out_q.pre;
  assign post_delay_us_o = out_q.post;
  assign last_o          = out_q.last;

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q < 4'(clnw_pkg::INIT_WRITES))
    else $error("step counter out of range");

  a_step_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q != '0) |-> head_valid_i)
    else $error("mid-sequence with empty queue");

  a_pop_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (wr_valid_q && out_q.last && step_q == '0))
    else $error("pop without last word");

  a_init_pre: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && step_q == '0 && head_i.kind == clnw_pkg::KIND_INIT)
      |=> out_q.pre == clnw_pkg::PWR_ON_US)
    else $error("init start without power-on wait");

endmodule

// ===== sv/char_lcd_nibble_writer_core.sv =====
// ----------------------------------------------------------------------------
// char_lcd_nibble_writer_core - 4-bit character LCD nibble writer
// Turns put/set/clear/init requests into nibble write words.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                 word
//  req      in         req_valid_i / req_stall_o req_type, char_code, cursor
//  cfg      in         cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//  wr       out        wr_valid_o / wr_stall_i   nibble, reg_select, delays, last
//
//  The sequencer sends one nibble word per cycle unless wr_stall_i holds it: a
//  character is 4 words, a clear 2, an initialise 14; newline, set cursor none.
//  The decoder takes a request each cycle until the QUEUE_DEPTH queue fills.
//  Reset puts the cursor at column 0 row 0, line length 16 and line count 2.
//  A stalled output word holds; the queue keeps requests coming meanwhile.
// ----------------------------------------------------------------------------
module char_lcd_nibble_writer_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        req_valid_i,
  output logic        req_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  char_code_i,
  input  logic [5:0]  cursor_col_i,
  input  logic        cursor_row_i,
  output logic        wr_valid_o,
  input  logic        wr_stall_i,
  output logic [3:0]  nibble_o,
  output logic        reg_select_o,
  output logic [14:0] pre_delay_us_o,
  output logic [10:0] post_delay_us_o,
  output logic        last_o
);

  logic             queue_full, push, pop, head_valid;
  clnw_pkg::entry_t push_entry, head;

  assign cfg_ready_o = 1'b1;
  assign req_stall_o = queue_full;

  clnw_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .req_valid_i  (req_valid_i),
    .req_type_i   (req_type_i),
    .char_code_i  (char_code_i),
    .cursor_col_i (cursor_col_i),
    .cursor_row_i (cursor_row_i),
    .queue_full_i (queue_full),
    .push_o       (push),
    .entry_o      (push_entry)
  );

  clnw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .full_o       (queue_full),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  clnw_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_valid_i    (head_valid),
    .head_i          (head),
    .pop_o           (pop),
    .wr_valid_o      (wr_valid_o),
    .wr_stall_i      (wr_stall_i),
    .nibble_o        (nibble_o),
    .reg_select_o    (reg_select_o),
    .pre_delay_us_o  (pre_delay_us_o),
    .post_delay_us_o (post_delay_us_o),
    .last_o          (last_o)
  );

endmodule

// ===== tb/clnw_nibble_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clnw_nibble_checker - scoreboard for the character LCD nibble writer
// Follows register writes and accepted requests, keeps its own cursor, works
// out the nibble words each request must produce and compares every output
// word, field by field, against the oldest word still owed.
// ----------------------------------------------------------------------------
module clnw_nibble_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        req_valid_i,
  input  logic        req_stall_i,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  char_code_i,
  input  logic [5:0]  cursor_col_i,
  input  logic        cursor_row_i,
  input  logic        wr_valid_i,
  input  logic        wr_stall_i,
  input  logic [3:0]  nibble_i,
  input  logic        reg_select_i,
  input  logic [14:0] pre_delay_us_i,
  input  logic [10:0] post_delay_us_i,
  input  logic        last_i,
  output int          mismatch_count_o,
  output int          words_owed_o
);

  localparam logic [7:0] SET_DDRAM  = 8'h80;
  localparam logic       RS_CMD     = 1'b0;
  localparam logic       RS_DATA    = 1'b1;

  typedef struct packed {
    logic [3:0]  nibble;
    logic        reg_select;
    logic [14:0] pre_delay;
    logic [10:0] post_delay;
    logic        last;
  } lcd_word_t;

  lcd_word_t  owed_words[$];
  lcd_word_t  request_words[$];

  logic [5:0] line_len;
  logic [1:0] line_cnt;
  logic [5:0] cursor_col;
  logic       cursor_row;
  int         mismatches;

  // Build helpers for the words of one request
  function automatic void add_word(logic [3:0] nib, logic rs, logic [14:0] pre,
                                   logic [10:0] post);
    lcd_word_t w;
    w.nibble     = nib;
    w.reg_select = rs;
    w.pre_delay  = pre;
    w.post_delay = post;
    w.last       = 1'b0;
    request_words.push_back(w);
  endfunction

  function automatic void add_byte(logic [7:0] b, logic rs, logic [10:0] post);
    add_word(b[7:4], rs, '0, '0);
    add_word(b[3:0], rs, '0, post);
  endfunction

  // Row wrap: zero lines acts as one, and the row is a single bit
  function automatic void next_row();
    logic [1:0] lines;
    logic [1:0] nxt;
    lines = (line_cnt == 2'd0) ? 2'd1 : line_cnt;
    nxt   = {1'b0, cursor_row} + 2'd1;
    if (nxt >= lines) nxt = 2'd0;
    cursor_row = nxt[0];
  endfunction

  // Work out the words for one accepted request and queue them
  function automatic void predict_request(clnw_pkg::req_e kind, logic [7:0] code,
                                          logic [5:0] col, logic row);
    request_words.delete();
    case (kind)
      clnw_pkg::REQ_PUT: begin
        if (code == clnw_pkg::NEWLINE_CODE) begin
          cursor_col = '0;
          next_row();
        end else begin
          add_byte(SET_DDRAM | {1'b0, cursor_row, cursor_col}, RS_CMD, '0);
          add_byte(code, RS_DATA, '0);
          if ({1'b0, cursor_col} + 7'd1 >= {1'b0, line_len}) begin
            cursor_col = '0;
            next_row();
          end else begin
            cursor_col = cursor_col + 6'd1;
          end
        end
      end
      clnw_pkg::REQ_SET: begin
        cursor_col = col;
        cursor_row = row;
      end
      clnw_pkg::REQ_CLEAR: begin
        add_byte(clnw_pkg::CMD_CLEAR, RS_CMD, clnw_pkg::CLEAR_US);
        cursor_col = '0;
        cursor_row = 1'b0;
      end
      default: begin
        add_word(clnw_pkg::NIB_WAKE, RS_CMD, clnw_pkg::PWR_ON_US, clnw_pkg::WAKE_US);
        add_word(clnw_pkg::NIB_WAKE, RS_CMD, '0, clnw_pkg::WAKE_US);
        add_word(clnw_pkg::NIB_WAKE, RS_CMD, '0, clnw_pkg::WAKE_US);
        add_word(clnw_pkg::NIB_4BIT, RS_CMD, '0, '0);
        add_byte(clnw_pkg::CMD_FUNC_SET, RS_CMD, '0);
        add_byte(clnw_pkg::CMD_DISP_ON, RS_CMD, '0);
        add_byte(clnw_pkg::CMD_ENTRY, RS_CMD, '0);
        add_byte(clnw_pkg::CMD_CLEAR, RS_CMD, '0);
        add_byte(clnw_pkg::CMD_CLEAR, RS_CMD, clnw_pkg::CLEAR_US);
        cursor_col = '0;
        cursor_row = 1'b0;
      end
    endcase
    if (request_words.size() > 0) request_words[request_words.size() - 1].last = 1'b1;
    foreach (request_words[i]) owed_words.push_back(request_words[i]);
  endfunction

  // Predict first, then compare, so ordering holds whatever the latency
  always @(posedge clk_i or negedge rst_ni) begin
    lcd_word_t want;
    if (!rst_ni) begin
      line_len   = clnw_pkg::LINE_LENGTH_RST;
      line_cnt   = clnw_pkg::LINE_COUNT_RST;
      cursor_col = '0;
      cursor_row = 1'b0;
      mismatches = 0;
      owed_words.delete();
      mismatch_count_o <= 0;
      words_owed_o     <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (clnw_pkg::cfg_e'(cfg_index_i))
          clnw_pkg::CFG_LINE_LENGTH: line_len = cfg_data_i[5:0];
          clnw_pkg::CFG_LINE_COUNT:  line_cnt = cfg_data_i[1:0];
          // strobe timing changes no word field
          clnw_pkg::CFG_STROBE_US:   ;
          default: ;
        endcase
      end
      if (req_valid_i && !req_stall_i)
        predict_request(clnw_pkg::req_e'(req_type_i), char_code_i, cursor_col_i,
                        cursor_row_i);
      if (wr_valid_i && !wr_stall_i) begin
        if (owed_words.size() == 0) begin
          $error("word with nothing owed: nibble %0h rs %0b last %0b",
                 nibble_i, reg_select_i, last_i);
          mismatches++;
        end else begin
          want = owed_words.pop_front();
          if (nibble_i !== want.nibble) begin
            $error("nibble: expected %0h, got %0h", want.nibble, nibble_i);
            mismatches++;
          end
          if (reg_select_i !== want.reg_select) begin
            $error("reg_select: expected %0b, got %0b", want.reg_select, reg_select_i);
            mismatches++;
          end
          if (pre_delay_us_i !== want.pre_delay) begin
            $error("pre_delay_us: expected %0d, got %0d", want.pre_delay, pre_delay_us_i);
            mismatches++;
          end
          if (post_delay_us_i !== want.post_delay) begin
            $error("post_delay_us: expected %0d, got %0d", want.post_delay,
                   post_delay_us_i);
            mismatches++;
          end
          if (last_i !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, last_i);
            mismatches++;
          end
        end
      end
      mismatch_count_o <= mismatches;
      words_owed_o     <= owed_words.size();
    end
  end

endmodule

// ===== tb/tb_char_lcd_nibble_writer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_char_lcd_nibble_writer_core - regression for the LCD nibble writer
// Drives directed and random requests over several register settings with
// random idling on both channels; the checker beside the block predicts and
// compares every nibble word, and this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_char_lcd_nibble_writer_core;

  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 27;
  localparam int CALM_PHASE      = 1;
  localparam int IDLE_PCT        = 9;
  localparam int SETTLE_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  logic        clk;
  logic        rst_n        = 1'b0;
  logic        cfg_valid    = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index    = '0;
  logic [7:0]  cfg_data     = '0;
  logic        req_valid    = 1'b0;
  logic        req_stall;
  logic [1:0]  req_type     = '0;
  logic [7:0]  char_code    = '0;
  logic [5:0]  cursor_col   = '0;
  logic        cursor_row   = 1'b0;
  logic        wr_valid;
  logic        wr_stall     = 1'b0;
  logic [3:0]  nibble;
  logic        reg_select;
  logic [14:0] pre_delay_us;
  logic [10:0] post_delay_us;
  logic        last;

  int          mismatch_count;
  int          words_owed;
  int          quiet_cycles = 0;
  bit          calm         = 1'b0;

  char_lcd_nibble_writer_core i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .req_valid_i    (req_valid),
    .req_stall_o    (req_stall),
    .req_type_i     (req_type),
    .char_code_i    (char_code),
    .cursor_col_i   (cursor_col),
    .cursor_row_i   (cursor_row),
    .wr_valid_o     (wr_valid),
    .wr_stall_i     (wr_stall),
    .nibble_o       (nibble),
    .reg_select_o   (reg_select),
    .pre_delay_us_o (pre_delay_us),
    .post_delay_us_o(post_delay_us),
    .last_o         (last)
  );

  clnw_nibble_checker i_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .req_valid_i     (req_valid),
    .req_stall_i     (req_stall),
    .req_type_i      (req_type),
    .char_code_i     (char_code),
    .cursor_col_i    (cursor_col),
    .cursor_row_i    (cursor_row),
    .wr_valid_i      (wr_valid),
    .wr_stall_i      (wr_stall),
    .nibble_i        (nibble),
    .reg_select_i    (reg_select),
    .pre_delay_us_i  (pre_delay_us),
    .post_delay_us_i (post_delay_us),
    .last_i          (last),
    .mismatch_count_o(mismatch_count),
    .words_owed_o    (words_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver back-pressure, off during the calm phase
  always @(negedge clk) begin
    wr_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
  end

  // Watchdog on cycles where no channel moves a word
  always @(posedge clk) begin
    if (!rst_n || (cfg_valid && cfg_ready) || (req_valid && !req_stall) ||
        (wr_valid && !wr_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Present one request word at a falling edge and hold it until taken
  task automatic send_request(clnw_pkg::req_e kind, logic [7:0] code, logic [5:0] col,
                              logic row);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid  <= 1'b1;
    req_type   <= kind;
    char_code  <= code;
    cursor_col <= col;
    cursor_row <= row;
    do @(posedge clk); while (req_stall);
    @(negedge clk);
  endtask

  // Mostly characters with some newlines, then cursor moves, clears, inits
  task automatic send_random();
    int             pick;
    clnw_pkg::req_e kind;
    logic [7:0]     code;
    pick = $urandom_range(99);
    code = 8'($urandom_range(255));
    if (pick < 60) begin
      kind = clnw_pkg::REQ_PUT;
      if ($urandom_range(9) == 0) code = clnw_pkg::NEWLINE_CODE;
    end else if (pick < 80) begin
      kind = clnw_pkg::REQ_SET;
    end else if (pick < 93) begin
      kind = clnw_pkg::REQ_CLEAR;
    end else begin
      kind = clnw_pkg::REQ_INIT;
    end
    send_request(kind, code, 6'($urandom_range(63)), 1'($urandom_range(1)));
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // Wait for every owed word, then let a request with no output finish
  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (words_owed != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    logic [5:0] lengths [PHASES] = '{6'd1, 6'd40, 6'd0, 6'd63, 6'd16, 6'd16};
    logic [1:0] counts  [PHASES] = '{2'd1, 2'd2, 2'd3, 2'd0, 2'd2, 2'd2};
    logic [7:0] strobes [PHASES] = '{8'd1, 8'd255, 8'd0, 8'd128, 8'd40, 8'd40};

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reset settings, wraps, odd cursor positions, code extremes
    send_request(clnw_pkg::REQ_INIT, 8'h00, 6'd0, 1'b0);
    send_request(clnw_pkg::REQ_PUT, 8'h48, 6'd0, 1'b0);
    send_request(clnw_pkg::REQ_PUT, 8'h00, 6'd0, 1'b0);
    send_request(clnw_pkg::REQ_PUT, 8'hff, 6'd0, 1'b0);
    send_request(clnw_pkg::REQ_PUT, clnw_pkg::NEWLINE_CODE, 6'd0, 1'b0);
    send_request(clnw_pkg::REQ_PUT, 8'h7e, 6'd0, 1'b0);
    send_request(clnw_pkg::REQ_SET, clnw_pkg::NEWLINE_CODE, 6'd63, 1'b1);
    send_request(clnw_pkg::REQ_PUT, 8'h55, 6'd0, 1'b0);
    send_request(clnw_pkg::REQ_SET, 8'h00, 6'd15, 1'b0);
    send_request(clnw_pkg::REQ_PUT, 8'haa, 6'd63, 1'b1);
    send_request(clnw_pkg::REQ_PUT, 8'h33, 6'd0, 1'b0);
    send_request(clnw_pkg::REQ_SET, 8'hff, 6'd15, 1'b1);
    send_request(clnw_pkg::REQ_PUT, 8'h01, 6'd0, 1'b0);
    send_request(clnw_pkg::REQ_PUT, clnw_pkg::NEWLINE_CODE, 6'd0, 1'b0);
    send_request(clnw_pkg::REQ_PUT, clnw_pkg::NEWLINE_CODE, 6'd0, 1'b0);
    send_request(clnw_pkg::REQ_SET, 8'h00, 6'd39, 1'b1);
    send_request(clnw_pkg::REQ_CLEAR, 8'h0a, 6'd39, 1'b1);
    send_request(clnw_pkg::REQ_PUT, 8'h80, 6'd0, 1'b0);
    send_request(clnw_pkg::REQ_SET, 8'hff, 6'd0, 1'b0);
    send_request(clnw_pkg::REQ_INIT, 8'hff, 6'd63, 1'b1);
    send_request(clnw_pkg::REQ_PUT, 8'h20, 6'd0, 1'b0);

    // Random phases, each on its own register setting
    for (int p = 0; p < PHASES; p++) begin
      drain();
      if (p >= 4) begin
        lengths[p] = 6'($urandom_range(1, 40));
        counts[p]  = 2'($urandom_range(1, 2));
        strobes[p] = 8'($urandom_range(255));
      end
      write_reg(clnw_pkg::CFG_LINE_LENGTH, {2'b00, lengths[p]});
      write_reg(clnw_pkg::CFG_LINE_COUNT, {6'd0, counts[p]});
      write_reg(clnw_pkg::CFG_STROBE_US, strobes[p]);
      if (p == 2) write_reg(CFG_UNUSED, 8'($urandom_range(255)));
      cfg_valid <= 1'b0;
      calm = (p == CALM_PHASE);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_random();
    end
    calm = 1'b0;
    drain();

    if (mismatch_count == 0 && words_owed == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/clnw_pkg.sv
sv/clnw_front.sv
sv/clnw_queue.sv
sv/clnw_back.sv
sv/char_lcd_nibble_writer_core.sv
tb/clnw_nibble_checker.sv
tb/tb_char_lcd_nibble_writer_core.sv
